/* src/apt_pkg.sv */
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types and constants of the affine point transform: coordinate
// and accumulator widths, stream packing and command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package apt_pkg;

    // Coordinate width is fixed by the stream fields.
    localparam int COORD_W  = 32;
    localparam int PROD_W   = 2 * COORD_W;
    // Three products and the scaled translation summed without loss.
    localparam int SUM_W    = PROD_W + 2;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 2;

    // Input payload: row, col, entry_value, px, py, pz, padded to bytes.
    localparam int IN_BITS  = 2 * IDX_W + 4 * COORD_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    // Output payload: out_x, out_y, out_z.
    localparam int OUT_W    = 3 * COORD_W;
    localparam int MASK_W   = 3;

    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE     = 2'd0,
        CMD_IDENTITY  = 2'd1,
        CMD_TRANSFORM = 2'd2
    } t_cmd;

endpackage : apt_pkg

`default_nettype wire

/* src/affine_point_transform.sv */
// ----------------------------------------------------------------------------
// affine_point_transform
// Transforms Q-format 3D points by a stored 4x4 matrix (row vector, w = 1)
// with floor rounding and per-axis saturation.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata (low bit up)                      tuser
//  s_axis    in         row, col, entry_value, px, py, pz, pad  command
//  m_axis    out        out_x, out_y, out_z                     clamp_mask
//
//  One request is taken per cycle while s_axis_tready is high. A transform
//  passes the registered stages multiply, pair add, final add, shift and saturate.
//  Matrix writes and the identity command update the matrix at the edge
//  they are taken and produce no result. Reset restores the identity.
//  When m_axis_tready is low the pipeline fills its empty stages before
//  s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_point_transform #(
    parameter int FRAC_BITS = 16
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,

    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    // row[1:0], col[3:2], entry_value[35:4], px[67:36], py[99:68], pz[131:100]
    input  wire  [apt_pkg::IN_W-1:0]   s_axis_tdata,
    // command[1:0]
    input  wire  [apt_pkg::CMD_W-1:0]  s_axis_tuser,

    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [apt_pkg::OUT_W-1:0]  m_axis_tdata,
    // clamp_mask[2:0]: x, y, z saturated
    output logic [apt_pkg::MASK_W-1:0] m_axis_tuser
);

    import apt_pkg::*;

    localparam logic [COORD_W-1:0] ONE = COORD_W'(1) << FRAC_BITS;

    // Input field split.
    logic [IDX_W-1:0]   w_row;
    logic [IDX_W-1:0]   w_col;
    logic [COORD_W-1:0] w_entry;
    t_coord             w_pt [3];
    t_cmd               w_cmd;
    logic               w_accept;

    assign w_row    = s_axis_tdata[IDX_W-1:0];
    assign w_col    = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign w_entry  = s_axis_tdata[2*IDX_W+COORD_W-1:2*IDX_W];
    assign w_pt[0]  = s_axis_tdata[2*IDX_W+2*COORD_W-1:2*IDX_W+COORD_W];
    assign w_pt[1]  = s_axis_tdata[2*IDX_W+3*COORD_W-1:2*IDX_W+2*COORD_W];
    assign w_pt[2]  = s_axis_tdata[2*IDX_W+4*COORD_W-1:2*IDX_W+3*COORD_W];
    assign w_cmd    = t_cmd'(s_axis_tuser);
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Pipeline valid bits and stage enables.
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    assign w_rdy4 = !r_v4 || m_axis_tready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign s_axis_tready = w_rdy1;

    // Matrix store, row-major, index row*4+col.
    logic [COORD_W-1:0] r_mat [16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= (i % 5 == 0) ? ONE : '0;
            end
        end else if (w_accept) begin
            case (w_cmd)
                CMD_WRITE: begin
                    r_mat[{w_row, w_col}] <= w_entry;
                end
                CMD_IDENTITY: begin
                    for (int i = 0; i < 16; i++) begin
                        r_mat[i] <= (i % 5 == 0) ? ONE : '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= w_accept && (w_cmd == CMD_TRANSFORM);
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    function automatic t_sum sx_prod(input t_prod v);
        return {{(SUM_W-PROD_W){v[PROD_W-1]}}, v};
    endfunction

    function automatic t_sum sx_trans(input logic [COORD_W-1:0] v);
        return {{(SUM_W-COORD_W-FRAC_BITS){v[COORD_W-1]}}, v, {FRAC_BITS{1'b0}}};
    endfunction

    // Stage 1: nine products and the translation row, read from the
    // matrix as it stands before this request.
    t_prod              r_prod [3][3];
    logic [COORD_W-1:0] r_trans [3];

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[c][k] <= w_pt[k] * $signed(r_mat[k*4+c]);
                end
                r_trans[c] <= r_mat[12+c];
            end
        end
    end

    // Stage 2: pairwise sums.
    t_sum r_pair_a [3];
    t_sum r_pair_b [3];

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            for (int c = 0; c < 3; c++) begin
                r_pair_a[c] <= sx_prod(r_prod[c][0]) + sx_prod(r_prod[c][1]);
                r_pair_b[c] <= sx_prod(r_prod[c][2]) + sx_trans(r_trans[c]);
            end
        end
    end

    // Stage 3: full sum per axis.
    t_sum r_sum [3];

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= r_pair_a[c] + r_pair_b[c];
            end
        end
    end

    // Stage 4: floor shift and saturation. The shifted value fits when
    // every bit from the coordinate sign upward agrees.
    t_sum               w_shift [3];
    logic [COORD_W-1:0] w_res   [3];
    logic [MASK_W-1:0]  w_clamp;
    logic [COORD_W-1:0] r_out   [3];
    logic [MASK_W-1:0]  r_clamp;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_shift[c] = r_sum[c] >>> FRAC_BITS;
            if ((&w_shift[c][SUM_W-1:COORD_W-1]) || !(|w_shift[c][SUM_W-1:COORD_W-1])) begin
                w_res[c]   = w_shift[c][COORD_W-1:0];
                w_clamp[c] = 1'b0;
            end else begin
                w_res[c]   = r_sum[c][SUM_W-1] ? COORD_MIN : COORD_MAX;
                w_clamp[c] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            for (int c = 0; c < 3; c++) begin
                r_out[c] <= w_res[c];
            end
            r_clamp <= w_clamp;
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {r_out[2], r_out[1], r_out[0]};
    assign m_axis_tuser  = r_clamp;

    // A clamped x axis carries one of the two range limits.
    a_clamp_x_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[COORD_W-1:0] == COORD_MAX ||
            m_axis_tdata[COORD_W-1:0] == COORD_MIN)
        else $error("clamped x is not a range limit");

    // An entry write lands in the addressed matrix slot.
    a_entry_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_cmd == CMD_WRITE |=>
            r_mat[$past({w_row, w_col})] == $past(w_entry))
        else $error("matrix entry write lost");

    // Input backpressure only comes from a full pipeline.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_v1 && r_v2 && r_v3 && r_v4 && !m_axis_tready)
        else $error("input stalled with a free stage");

endmodule : affine_point_transform

`default_nettype wire

/* tb/affine_point_transform_test.sv */
// ----------------------------------------------------------------------------
// affine_point_transform_test
// Self-checking bench for the affine point transform. Matrix writes,
// identity loads, unused codes and point transforms are streamed in with
// random gaps on both channels. A scoreboard keeps its own copy of the
// matrix and queues the floor-rounded, saturated coordinates that each
// transform request must produce.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_point_transform_test;

    timeunit 1ns;
    timeprecision 1ps;

    import apt_pkg::*;

    localparam int FRAC = 16;
    localparam int RANDOM_ITEMS = 1850;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam t_coord Q_ONE = 32'sh0001_0000;

    // Wide enough for three full products plus the scaled translation.
    typedef logic signed [79:0] t_wide;
    localparam t_wide SUM_HI = 80'sd2147483647;
    localparam t_wide SUM_LO = -80'sd2147483648;

    typedef struct packed {
        t_coord             x;
        t_coord             y;
        t_coord             z;
        logic [MASK_W-1:0]  clamp;
    } t_point_result;

    class transform_scoreboard;
        t_coord         matrix[16];
        t_point_result  expected_points[$];
        int             mismatches;

        function new();
            mismatches = 0;
            load_identity();
        endfunction

        function void load_identity();
            for (int i = 0; i < 16; i++) begin
                matrix[i] = (i % 5 == 0) ? Q_ONE : '0;
            end
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        function t_point_result transform_point(t_coord px, t_coord py, t_coord pz);
            t_point_result r;
            t_wide         sum;
            t_coord        axis_out[3];
            r.clamp = '0;
            for (int c = 0; c < 3; c++) begin
                sum = t_wide'(px) * t_wide'(matrix[c])
                    + t_wide'(py) * t_wide'(matrix[4 + c])
                    + t_wide'(pz) * t_wide'(matrix[8 + c])
                    + (t_wide'(matrix[12 + c]) <<< FRAC);
                sum = sum >>> FRAC;
                if (sum > SUM_HI) begin
                    axis_out[c] = COORD_MAX;
                    r.clamp[c] = 1'b1;
                end else if (sum < SUM_LO) begin
                    axis_out[c] = COORD_MIN;
                    r.clamp[c] = 1'b1;
                end else begin
                    axis_out[c] = sum[COORD_W-1:0];
                end
            end
            r.x = axis_out[0];
            r.y = axis_out[1];
            r.z = axis_out[2];
            return r;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row,
                                   logic [IDX_W-1:0] col, t_coord value,
                                   t_coord px, t_coord py, t_coord pz);
            case (cmd)
                CMD_WRITE:     matrix[{row, col}] = value;
                CMD_IDENTITY:  load_identity();
                CMD_TRANSFORM: expected_points.push_back(transform_point(px, py, pz));
                default: ;
            endcase
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 100) begin
                $display("[%0t] mismatch: %s", $realtime, what);
            end
        endtask

        task check_result(t_coord gx, t_coord gy, t_coord gz, logic [MASK_W-1:0] gmask);
            t_point_result want;
            if (expected_points.size() == 0) begin
                report($sformatf("result with no request waiting: x=%h y=%h z=%h clamp=%b",
                                 gx, gy, gz, gmask));
                return;
            end
            want = expected_points.pop_front();
            if (gx !== want.x)
                report($sformatf("out_x got %h want %h", gx, want.x));
            if (gy !== want.y)
                report($sformatf("out_y got %h want %h", gy, want.y));
            if (gz !== want.z)
                report($sformatf("out_z got %h want %h", gz, want.z));
            if (gmask !== want.clamp)
                report($sformatf("clamp_mask got %b want %b", gmask, want.clamp));
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;
    logic [CMD_W-1:0]     s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic [MASK_W-1:0]    m_axis_tuser;

    transform_scoreboard  sb = new();

    int                   send_idle_pct = 16;
    int                   recv_idle_pct = 71;
    bit                   quiet = 1'b0;

    affine_point_transform #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Result side: check every accepted result and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata[COORD_W-1:0], m_axis_tdata[2*COORD_W-1:COORD_W],
                            m_axis_tdata[3*COORD_W-1:2*COORD_W], m_axis_tuser);
        end
        m_axis_tready <= ($urandom_range(99) >= (quiet ? 0 : recv_idle_pct));
    end

    task automatic send_request(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row,
                                logic [IDX_W-1:0] col, t_coord value,
                                t_coord px, t_coord py, t_coord pz);
        while ($urandom_range(99) < (quiet ? 0 : send_idle_pct)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(IN_W - IN_BITS){1'b0}}, pz, py, px, value, col, row};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(cmd, row, col, value, px, py, pz);
    endtask

    // Hold off new requests until every queued result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic [IDX_W-1:0] rand_idx();
        return IDX_W'($urandom);
    endfunction

    // Mix of full-range, near-unity, mid-range, boundary and small whole values.
    function automatic t_coord rand_coord();
        case ($urandom_range(4))
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(262143)) - 131072;
            2: return t_coord'($urandom_range(33554431)) - 16777216;
            3: begin
                case ($urandom_range(4))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return '0;
                    3: return Q_ONE;
                    default: return -Q_ONE;
                endcase
            end
            default: return t_coord'($urandom_range(15)) * Q_ONE - 8 * Q_ONE;
        endcase
    endfunction

    initial begin
        int              counted;
        int              phase;
        int              last_phase;
        int              pick;
        logic [CMD_W-1:0] cmd;

        counted = 0;
        last_phase = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Identity after reset, including the coordinate extremes.
        send_request(CMD_TRANSFORM, rand_idx(), rand_idx(), $urandom,
                     Q_ONE + 32'sh8000, 2 * Q_ONE, -3 * Q_ONE);
        send_request(CMD_TRANSFORM, rand_idx(), rand_idx(), $urandom, COORD_MAX, COORD_MIN, '0);
        send_request(CMD_TRANSFORM, rand_idx(), rand_idx(), $urandom, -1, 1, -1);
        // A one-LSB scale turns small negatives into floor results.
        send_request(CMD_WRITE, 2'd0, 2'd0, 32'sd1, $urandom, $urandom, $urandom);
        send_request(CMD_TRANSFORM, rand_idx(), rand_idx(), $urandom, -1, Q_ONE, -Q_ONE);
        // Maximum translation pushes x over the top by one.
        send_request(CMD_WRITE, 2'd3, 2'd0, COORD_MAX, $urandom, $urandom, $urandom);
        send_request(CMD_TRANSFORM, rand_idx(), rand_idx(), $urandom, '0, '0, '0);
        send_request(CMD_TRANSFORM, rand_idx(), rand_idx(), $urandom, Q_ONE, '0, '0);
        // Large negative products saturate to the minimum.
        send_request(CMD_WRITE, 2'd1, 2'd1, COORD_MIN, $urandom, $urandom, $urandom);
        send_request(CMD_WRITE, 2'd2, 2'd2, COORD_MAX, $urandom, $urandom, $urandom);
        send_request(CMD_TRANSFORM, rand_idx(), rand_idx(), $urandom,
                     '0, COORD_MAX, COORD_MIN);
        send_request(CMD_WRITE, 2'd3, 2'd3, t_coord'($urandom), $urandom, $urandom, $urandom);
        send_request(CMD_WRITE, 2'd0, 2'd3, COORD_MIN, $urandom, $urandom, $urandom);
        send_request(CMD_WRITE, 2'd3, 2'd2, COORD_MIN, $urandom, $urandom, $urandom);
        // The unused code must leave the matrix alone.
        send_request(CMD_UNUSED, rand_idx(), rand_idx(), $urandom, $urandom, $urandom, $urandom);
        send_request(CMD_TRANSFORM, rand_idx(), rand_idx(), $urandom,
                     COORD_MIN, COORD_MIN, Q_ONE);
        send_request(CMD_IDENTITY, rand_idx(), rand_idx(), $urandom,
                     $urandom, $urandom, $urandom);
        send_request(CMD_TRANSFORM, rand_idx(), rand_idx(), $urandom,
                     COORD_MAX, COORD_MAX, COORD_MAX);
        send_request(CMD_TRANSFORM, rand_idx(), rand_idx(), $urandom,
                     COORD_MIN, COORD_MIN, COORD_MIN);
        drain_results();

        while (counted < RANDOM_ITEMS) begin
            phase = counted * 3 / RANDOM_ITEMS;
            if (phase != last_phase) begin
                drain_results();
                send_idle_pct = (phase == 1) ? 71 : 0;
                recv_idle_pct = (phase == 1) ? 16 : 0;
                last_phase = phase;
            end
            if (counted % 40 == 0) begin
                quiet = ($urandom_range(3) == 0);
            end
            pick = $urandom_range(99);
            if (pick < 18)
                cmd = CMD_WRITE;
            else if (pick < 21)
                cmd = CMD_IDENTITY;
            else if (pick < 25)
                cmd = CMD_UNUSED;
            else
                cmd = CMD_TRANSFORM;
            send_request(cmd, rand_idx(), rand_idx(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord());
            if (cmd != CMD_UNUSED) begin
                counted++;
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d transform results never arrived", sb.pending()));
        end
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
